/* hdl/olr_pkg.sv */
// Package with the shared types and constants of the ordered list block.
`timescale 1ns / 1ps

package olr_pkg;

  localparam int CMD_W  = 3;
  localparam int DATA_W = 32;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 5;

  typedef enum logic [CMD_W-1:0] {
    OP_APPEND   = 3'd0,
    OP_REM_HEAD = 3'd1,
    OP_REM_TAIL = 3'd2,
    OP_REM_POS  = 3'd3,
    OP_DUMP     = 3'd4,
    OP_CLEAR    = 3'd5
  } olr_op_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } olr_status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } olr_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic exec;        // execute the accepted request and load its result
    logic dump_start;  // clear the dump counter
    logic dump_step;   // emit the head element and rotate the list
  } olr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;       // list holds no element
    logic dump_last;   // the next dump step emits the final element
  } olr_stat_t;

endpackage

/* hdl/olr_ctrl.sv */
// Controller state machine for the ordered list: handshakes and dump sequencing.
`timescale 1ns / 1ps

module olr_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [olr_pkg::CMD_W-1:0]       cmd_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output olr_pkg::olr_cmd_t               cmd_o,
  input  olr_pkg::olr_stat_t              stat_i
);

  olr_pkg::olr_state_e state_q, state_d;
  logic                out_valid_q, out_valid_d;
  logic                slot_free;
  logic                accept;
  logic                is_dump;

  // The output register can take a new result when it is empty or being emptied.
  assign slot_free = !out_valid_q || !out_stall_i;
  assign is_dump   = (olr_pkg::olr_op_e'(cmd_i) == olr_pkg::OP_DUMP);
  assign accept    = in_valid_i && !in_stall_o;

  always_comb begin
    state_d = state_q;
    case (state_q)
      olr_pkg::S_IDLE: begin
        if (accept && is_dump && !stat_i.empty) begin
          state_d = olr_pkg::S_DUMP;
        end
      end
      olr_pkg::S_DUMP: begin
        if (slot_free && stat_i.dump_last) begin
          state_d = olr_pkg::S_IDLE;
        end
      end
      default: state_d = olr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o       = 1'b1;
    cmd_o.exec       = 1'b0;
    cmd_o.dump_start = 1'b0;
    cmd_o.dump_step  = 1'b0;
    case (state_q)
      olr_pkg::S_IDLE: begin
        in_stall_o = !slot_free;
        if (in_valid_i && slot_free) begin
          if (is_dump && !stat_i.empty) begin
            cmd_o.dump_start = 1'b1;
          end else begin
            cmd_o.exec = 1'b1;
          end
        end
      end
      olr_pkg::S_DUMP: begin
        cmd_o.dump_step = slot_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  always_comb begin
    if (cmd_o.exec || cmd_o.dump_step) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= olr_pkg::S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_dump_blocks_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == olr_pkg::S_DUMP |-> in_stall_o)
    else $error("request accepted during a dump");

  a_single_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_dump |=> out_valid_q)
    else $error("accepted request produced no result");

  a_dump_needs_data : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.dump_step |-> !stat_i.empty)
    else $error("dump step on an empty list");

endmodule

/* hdl/olr_dp.sv */
// Datapath for the ordered list: element cells, count, dump counter and result register.
`timescale 1ns / 1ps

module olr_dp #(
  parameter int DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  olr_pkg::olr_cmd_t                   cmd_i,
  input  logic [olr_pkg::CMD_W-1:0]           op_i,
  input  logic signed [olr_pkg::DATA_W-1:0]   value_i,
  input  logic [olr_pkg::POS_W-1:0]           position_i,
  output olr_pkg::olr_stat_t                  stat_o,
  output logic [olr_pkg::STAT_W-1:0]          status_o,
  output logic signed [olr_pkg::DATA_W-1:0]   element_o,
  output logic [olr_pkg::LEN_W-1:0]           length_o,
  output logic                                last_o
);

  localparam int CW    = $clog2(DEPTH + 1);
  localparam int IW    = $clog2(DEPTH);
  localparam int CmpW  = (CW > olr_pkg::POS_W) ? CW : olr_pkg::POS_W;
  localparam int LenW  = olr_pkg::LEN_W;
  localparam int DataW = olr_pkg::DATA_W;

  logic signed [DataW-1:0] cells_q [DEPTH];
  logic signed [DataW-1:0] cells_d [DEPTH];
  logic [CW-1:0]           count_q, count_d;
  logic [IW-1:0]           dump_idx_q, dump_idx_d;

  olr_pkg::olr_status_e    status_d;
  logic signed [DataW-1:0] element_d;
  logic                    last_d;
  logic                    rm;
  logic [IW-1:0]           rm_idx;
  logic                    empty;
  logic                    dump_last;

  logic [olr_pkg::STAT_W-1:0] status_q;
  logic signed [DataW-1:0]    element_q;
  logic [LenW-1:0]            length_q;
  logic                       last_q;

  assign empty     = (count_q == '0);
  assign dump_last = ((CW'(dump_idx_q) + CW'(1)) == count_q);

  always_comb begin
    cells_d    = cells_q;
    count_d    = count_q;
    dump_idx_d = dump_idx_q;
    status_d   = olr_pkg::ST_OK;
    element_d  = '0;
    last_d     = 1'b1;
    rm         = 1'b0;
    rm_idx     = '0;

    if (cmd_i.exec) begin
      case (olr_pkg::olr_op_e'(op_i))
        olr_pkg::OP_APPEND: begin
          if (count_q == CW'(DEPTH)) begin
            status_d = olr_pkg::ST_FULL;
          end else begin
            for (int i = 0; i < DEPTH; i++) begin
              if (i == int'(count_q)) cells_d[i] = value_i;
            end
            count_d = count_q + CW'(1);
          end
        end
        olr_pkg::OP_REM_HEAD: begin
          if (empty) status_d = olr_pkg::ST_EMPTY;
          else rm = 1'b1;
        end
        olr_pkg::OP_REM_TAIL: begin
          if (empty) begin
            status_d = olr_pkg::ST_EMPTY;
          end else begin
            rm     = 1'b1;
            rm_idx = IW'(count_q - CW'(1));
          end
        end
        olr_pkg::OP_REM_POS: begin
          if (empty) begin
            status_d = olr_pkg::ST_EMPTY;
          end else if (CmpW'(position_i) >= CmpW'(count_q)) begin
            status_d = olr_pkg::ST_RANGE;
          end else begin
            rm     = 1'b1;
            rm_idx = IW'(position_i);
          end
        end
        olr_pkg::OP_DUMP: begin
          if (empty) status_d = olr_pkg::ST_EMPTY;
        end
        olr_pkg::OP_CLEAR: begin
          count_d = '0;
        end
        default: status_d = olr_pkg::ST_OK;
      endcase

      // Removal closes the gap by moving every cell above the index down by one.
      if (rm) begin
        element_d = cells_q[rm_idx];
        for (int i = 0; i < DEPTH - 1; i++) begin
          if (i >= int'(rm_idx)) cells_d[i] = cells_q[i + 1];
        end
        count_d = count_q - CW'(1);
      end
    end

    if (cmd_i.dump_start) begin
      dump_idx_d = '0;
    end

    // A dump step emits the head and rotates it to the tail, so after a full
    // dump the list is back in its original order.
    if (cmd_i.dump_step) begin
      element_d = cells_q[0];
      last_d    = dump_last;
      for (int i = 0; i < DEPTH; i++) begin
        if (i + 1 < int'(count_q)) cells_d[i] = cells_q[(i + 1) % DEPTH];
        else if (i + 1 == int'(count_q)) cells_d[i] = cells_q[0];
      end
      dump_idx_d = dump_idx_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      dump_idx_q <= '0;
    end else begin
      count_q    <= count_d;
      dump_idx_q <= dump_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cells_q <= cells_d;
    if (cmd_i.exec || cmd_i.dump_step) begin
      status_q  <= status_d;
      element_q <= element_d;
      length_q  <= LenW'(count_d);
      last_q    <= last_d;
    end
  end

  assign stat_o.empty     = empty;
  assign stat_o.dump_last = dump_last;
  assign status_o         = status_q;
  assign element_o        = element_q;
  assign length_o         = length_q;
  assign last_o           = last_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("element count exceeds depth");

endmodule

/* hdl/ordered_list_with_indexed_removal.sv */
// Top level of the ordered list with append, head/tail/indexed removal, dump and clear.
// Each accepted request is executed at once and its result reaches the output register in the cycle
// after acceptance; a non-empty dump first starts the rotation, then loads its elements as the output frees.
// Throughput: one request per cycle while the output is not stalled, for every command but a non-empty
// dump, set by the single output register; a dump streams one element per cycle while the output is not stalled.
// Reset clears the element count, the controller state and the output valid; cells are not reset.
`timescale 1ns / 1ps

module ordered_list_with_indexed_removal #(
  parameter int DEPTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [olr_pkg::CMD_W-1:0]           cmd_i,
  input  logic signed [olr_pkg::DATA_W-1:0]   value_i,
  input  logic [olr_pkg::POS_W-1:0]           position_i,

  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [olr_pkg::STAT_W-1:0]          status_o,
  output logic signed [olr_pkg::DATA_W-1:0]   element_o,
  output logic [olr_pkg::LEN_W-1:0]           length_o,
  output logic                                last_o
);

  // The controller owns the handshakes and sequences dumps; the datapath holds
  // the list as a row of cells; on a removal the cells above the removed one shift down in parallel.
  olr_pkg::olr_cmd_t  dp_cmd;
  olr_pkg::olr_stat_t dp_stat;

  olr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd),
    .stat_i      (dp_stat)
  );

  // Each request is executed in the cycle it is accepted and its result is
  // registered; a non-empty dump request instead starts a rotation of the list, one
  // element leaving the head per cycle that the output register is free.
  olr_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (dp_cmd),
    .op_i       (cmd_i),
    .value_i    (value_i),
    .position_i (position_i),
    .stat_o     (dp_stat),
    .status_o   (status_o),
    .element_o  (element_o),
    .length_o   (length_o),
    .last_o     (last_o)
  );

endmodule

/* tb/tb.sv */
// Self-checking testbench for the ordered list with indexed removal.
`timescale 1ns / 1ps

// One response as the block should present it.
typedef struct packed {
  olr_pkg::olr_status_e  status;
  logic signed [31:0]    element;
  logic [4:0]            length;
  logic                  last;
} list_result_t;

// Tracks the list contents and the responses that each accepted request must produce.
class list_scoreboard;
  logic signed [31:0] cells[$];
  list_result_t       awaited[$];
  int                 depth;
  int                 errors;

  function new(int depth_limit);
    depth  = depth_limit;
    errors = 0;
  endfunction

  function void queue_result(olr_pkg::olr_status_e status, logic signed [31:0] element,
                             logic last);
    list_result_t r;
    r.status  = status;
    r.element = element;
    r.length  = 5'(cells.size());
    r.last    = last;
    awaited.push_back(r);
  endfunction

  // Applies one accepted request to the list and queues the responses it causes.
  function void note_request(logic [2:0] cmd, logic signed [31:0] value, logic [3:0] pos);
    logic signed [31:0] taken;
    int                 i;
    case (cmd)
      olr_pkg::OP_APPEND: begin
        if (cells.size() >= depth) begin
          queue_result(olr_pkg::ST_FULL, 0, 1'b1);
        end else begin
          cells.push_back(value);
          queue_result(olr_pkg::ST_OK, 0, 1'b1);
        end
      end
      olr_pkg::OP_REM_HEAD: begin
        if (cells.size() == 0) begin
          queue_result(olr_pkg::ST_EMPTY, 0, 1'b1);
        end else begin
          taken = cells.pop_front();
          queue_result(olr_pkg::ST_OK, taken, 1'b1);
        end
      end
      olr_pkg::OP_REM_TAIL: begin
        if (cells.size() == 0) begin
          queue_result(olr_pkg::ST_EMPTY, 0, 1'b1);
        end else begin
          taken = cells.pop_back();
          queue_result(olr_pkg::ST_OK, taken, 1'b1);
        end
      end
      olr_pkg::OP_REM_POS: begin
        // The empty check wins over the range check.
        if (cells.size() == 0) begin
          queue_result(olr_pkg::ST_EMPTY, 0, 1'b1);
        end else if (int'(pos) >= cells.size()) begin
          queue_result(olr_pkg::ST_RANGE, 0, 1'b1);
        end else begin
          taken = cells[pos];
          cells.delete(pos);
          queue_result(olr_pkg::ST_OK, taken, 1'b1);
        end
      end
      olr_pkg::OP_DUMP: begin
        if (cells.size() == 0) begin
          queue_result(olr_pkg::ST_EMPTY, 0, 1'b1);
        end else begin
          for (i = 0; i < cells.size(); i++) begin
            queue_result(olr_pkg::ST_OK, cells[i], i == cells.size() - 1);
          end
        end
      end
      olr_pkg::OP_CLEAR: begin
        cells.delete();
        queue_result(olr_pkg::ST_OK, 0, 1'b1);
      end
      // Reserved codes leave the list alone and answer with a plain ok.
      default: queue_result(olr_pkg::ST_OK, 0, 1'b1);
    endcase
  endfunction

  function void compare_field(string name, logic signed [32:0] expected,
                              logic signed [32:0] actual);
    if (actual !== expected) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expected, actual);
      errors++;
    end
  endfunction

  function void check_result(logic [1:0] status, logic signed [31:0] element,
                             logic [4:0] length, logic last);
    list_result_t exp;
    if (awaited.size() == 0) begin
      $error("response with none pending: status %0d element %0d length %0d last %0d",
             status, element, length, last);
      errors++;
      return;
    end
    exp = awaited.pop_front();
    compare_field("status", exp.status, status);
    compare_field("element", exp.element, element);
    compare_field("length", exp.length, length);
    compare_field("last", exp.last, last);
  endfunction
endclass

module tb;

  localparam int LIST_DEPTH  = 16;
  localparam int HOLD_CYCLES = 80;
  // Codes the block must ignore.
  localparam logic [2:0] OP_RSVD_6 = 3'd6;
  localparam logic [2:0] OP_RSVD_7 = 3'd7;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [2:0]         cmd_i = olr_pkg::OP_CLEAR;
  logic signed [31:0] value_i = '0;
  logic [3:0]         position_i = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [1:0]         status_o;
  logic signed [31:0] element_o;
  logic [4:0]         length_o;
  logic               last_o;

  // Random idling on both sides, and a one-shot request for a long output hold-off.
  bit idle_on = 1'b1;
  bit hold_req = 1'b0;

  list_scoreboard sb = new(LIST_DEPTH);

  ordered_list_with_indexed_removal #(.DEPTH(LIST_DEPTH)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .element_o   (element_o),
    .length_o    (length_o),
    .last_o      (last_o)
  );

  always #1 clk_i = ~clk_i;

  // Both channels are observed at the rising edge, before the block updates.
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      sb.note_request(cmd_i, value_i, position_i);
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result(status_o, element_o, length_o, last_o);
    end
  end

  // Output side: random stalls, or a long hold-off so the block backs up into its input.
  always begin
    @(negedge clk_i);
    if (hold_req) begin
      hold_req = 1'b0;
      out_stall_i <= 1'b1;
      repeat (HOLD_CYCLES) @(negedge clk_i);
    end else begin
      out_stall_i <= idle_on && ($urandom_range(99) < 33);
    end
  end

  // Offers one request, idling first at random, and returns once it is accepted.
  task automatic send_request(input logic [2:0] cmd, input logic signed [31:0] val,
                              input logic [3:0] pos);
    @(negedge clk_i);
    while (idle_on && $urandom_range(99) < 33) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    cmd_i      <= cmd;
    value_i    <= val;
    position_i <= pos;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Values lean toward the sign and all-ones extremes.
  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return 32'sh0000_0000;
      3:       return -32'sd1;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int                 i;
    int                 r;
    int                 fill;
    logic [2:0]         op;
    logic [3:0]         pos;
    logic signed [31:0] fixed_vals[6];

    fixed_vals = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1,
                   32'sh5555_5555, 32'shAAAA_AAAA};

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: every removal and a dump on an empty list, then fill to the brim.
    send_request(olr_pkg::OP_DUMP, $urandom, 4'd0);
    send_request(olr_pkg::OP_REM_HEAD, $urandom, 4'd0);
    send_request(olr_pkg::OP_REM_TAIL, $urandom, 4'd0);
    send_request(olr_pkg::OP_REM_POS, $urandom, 4'd15);
    for (i = 0; i < LIST_DEPTH; i++) begin
      send_request(olr_pkg::OP_APPEND, (i < 6) ? fixed_vals[i] : $urandom, 4'($urandom));
    end
    // Append to a full list, a full dump, then indexed removal at and past the tail.
    send_request(olr_pkg::OP_APPEND, 32'sh1234_5678, 4'd0);
    send_request(olr_pkg::OP_DUMP, $urandom, 4'($urandom));
    send_request(olr_pkg::OP_REM_POS, $urandom, 4'd15);
    send_request(olr_pkg::OP_REM_POS, $urandom, 4'd15);
    send_request(olr_pkg::OP_REM_POS, $urandom, 4'd7);
    send_request(olr_pkg::OP_REM_HEAD, $urandom, 4'($urandom));
    send_request(olr_pkg::OP_REM_TAIL, $urandom, 4'($urandom));
    send_request(OP_RSVD_6, $urandom, 4'($urandom));
    send_request(OP_RSVD_7, $urandom, 4'($urandom));
    send_request(olr_pkg::OP_CLEAR, $urandom, 4'($urandom));

    // Random part. Alternate stretches favor appends so the list reaches full depth
    // often; positions mostly land inside the list, sometimes past it.
    for (i = 0; i < 170; i++) begin
      idle_on = !(i >= 60 && i < 110);
      if (i == 70) hold_req = 1'b1;
      fill = ((i / 25) % 2 == 0) && ($urandom_range(1) == 1);
      r = $urandom_range(99);
      if (fill)        op = olr_pkg::OP_APPEND;
      else if (r < 10) op = olr_pkg::OP_REM_HEAD;
      else if (r < 20) op = olr_pkg::OP_REM_TAIL;
      else if (r < 40) op = olr_pkg::OP_REM_POS;
      else if (r < 47) op = olr_pkg::OP_DUMP;
      else if (r < 50) op = olr_pkg::OP_CLEAR;
      else if (r < 53) op = $urandom_range(1) ? OP_RSVD_7 : OP_RSVD_6;
      else             op = olr_pkg::OP_APPEND;
      if (sb.cells.size() > 0 && $urandom_range(99) < 80) begin
        pos = 4'($urandom_range(sb.cells.size() - 1));
      end else begin
        pos = 4'($urandom_range(15));
      end
      send_request(op, pick_value(), pos);
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    idle_on = 1'b1;

    // Drain, then keep watching for any stray response before the verdict.
    while (sb.awaited.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
